/* sv/pixel_palette_indexer_assert.svh */
// Assertion macros shared by the palette indexer RTL
`ifndef PIXEL_PALETTE_INDEXER_ASSERT_SVH
`define PIXEL_PALETTE_INDEXER_ASSERT_SVH

// checked only while out of reset
`define PPI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define PPI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* sv/ppi_pkg.sv */
// Types and constants of the pixel palette indexer
package ppi_pkg;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    localparam logic [15:0] TRANSPARENT_CODE  = 16'hFFFF;
    localparam int          CFG_DATA_W        = 9;
    localparam logic        REG_PALETTE_LIMIT = 1'b0;
    localparam logic        REG_ALPHA_PRESENT = 1'b1;
    localparam logic [8:0]  LIMIT_RESET       = 9'd256;
    localparam int          COLOR_W           = 16;
    localparam int          INDEX_W           = 8;

endpackage

/* sv/ppi_ram.sv */
// Generic single-write, single-read RAM with registered read data
module ppi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/pixel_palette_indexer.sv */
// Pixel palette indexer: RGBA to BGR555 code and palette index lookup/append
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------------
//  input   | in        | i_in_valid / o_in_ready   | red, green, blue, alpha, first_pixel
//  result  | out       | o_out_valid / i_out_ready | pixel_index, new_entry, entry_color,
//          |           |                           | too_many_colors
//  config  | in        | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// A request is accepted in idle; the scan then reads one palette entry per cycle from the RAM port,
// from entry 1 up to the last used entry, and compares each registered read word with the code.
// Transparent pixels and overflowed images finish without a RAM read. Entry 0 is held as a constant,
// so reset needs no clearing pass. A result waiting on i_out_ready holds the scan unit;
// the next request is taken as soon as the unit returns to idle.
module pixel_palette_indexer #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_red,
    input  logic [7:0]                     i_green,
    input  logic [7:0]                     i_blue,
    input  logic [7:0]                     i_alpha,
    input  logic                           i_first_pixel,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [ppi_pkg::INDEX_W-1:0]    o_pixel_index,
    output logic                           o_new_entry,
    output logic [ppi_pkg::COLOR_W-1:0]    o_entry_color,
    output logic                           o_too_many_colors,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [ppi_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import ppi_pkg::*;

    `include "pixel_palette_indexer_assert.svh"

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int CW = $clog2(PALETTE_DEPTH + 1);
    localparam int LW = CW + CFG_DATA_W;

    t_state r_state, n_state;

    logic [CFG_DATA_W-1:0] r_limit;
    logic                  r_alpha_en;

    logic [COLOR_W-1:0] r_code;
    logic               r_hit0;
    logic               r_ovf;
    logic [CW-1:0]      r_used;
    logic [CW-1:0]      r_j;
    logic [CW-1:0]      r_pend_j;
    logic               r_pend;

    logic               r_out_valid;
    logic [INDEX_W-1:0] r_out_idx;
    logic               r_out_new;
    logic [COLOR_W-1:0] r_out_color;
    logic               r_out_ovf;

    logic [COLOR_W-1:0] in_code;
    logic               accept;
    logic               out_free;
    logic               hit;
    logic               more;
    logic               issue;
    logic               finish;
    logic               miss;
    logic               room;
    logic               append;
    logic               ovf_set;
    logic [LW-1:0]      lim_ext;
    logic [LW-1:0]      lim_eff;
    logic [LW-1:0]      res_idx;
    logic [COLOR_W-1:0] rd_data;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        in_code = {1'b0, i_blue[7:3], i_green[7:3], i_red[7:3]};
        if (r_alpha_en && (i_alpha == 8'd0)) begin
            in_code = TRANSPARENT_CODE;
        end
    end

    always_comb begin
        lim_ext = LW'(r_limit);
        priority if (lim_ext == LW'(0)) begin
            lim_eff = LW'(1);
        end else if (lim_ext > LW'(PALETTE_DEPTH)) begin
            lim_eff = LW'(PALETTE_DEPTH);
        end else begin
            lim_eff = lim_ext;
        end
    end

    always_comb begin
        unique case (r_state)
            ST_IDLE: n_state = accept ? ST_SCAN : ST_IDLE;
            ST_SCAN: n_state = finish ? ST_IDLE : ST_SCAN;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        hit        = r_pend && (rd_data == r_code);
        more       = r_j < r_used;
        issue      = (r_state == ST_SCAN) && !r_ovf && !r_hit0 && !hit && more;
        miss       = !r_ovf && !r_hit0 && !hit && !more;
        finish     = (r_state == ST_SCAN) && !issue && out_free;
        room       = LW'(r_used) < lim_eff;
        append     = finish && miss && room;
        ovf_set    = finish && miss && !room;
        priority if (r_ovf || r_hit0 || (miss && !room)) begin
            res_idx = LW'(0);
        end else if (hit) begin
            res_idx = LW'(r_pend_j);
        end else begin
            res_idx = LW'(r_used);
        end
    end

    ppi_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (append),
        .i_waddr (r_used[AW-1:0]),
        .i_wdata (r_code),
        .i_re    (issue),
        .i_raddr (r_j[AW-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_limit     <= LIMIT_RESET;
            r_alpha_en  <= 1'b1;
            r_used      <= CW'(1);
            r_ovf       <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_PALETTE_LIMIT: r_limit    <= i_cfg_data;
                    REG_ALPHA_PRESENT: r_alpha_en <= i_cfg_data[0];
                    default:           r_limit    <= r_limit;
                endcase
            end
            if (accept) begin
                r_pend <= 1'b0;
                if (i_first_pixel) begin
                    r_used <= CW'(1);
                    r_ovf  <= 1'b0;
                end
            end else if (issue) begin
                r_pend <= 1'b1;
            end else if (finish) begin
                r_pend <= 1'b0;
                if (append) begin
                    r_used <= r_used + CW'(1);
                end
                if (ovf_set) begin
                    r_ovf <= 1'b1;
                end
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_code <= in_code;
            r_hit0 <= (in_code == TRANSPARENT_CODE);
            r_j    <= CW'(1);
        end else if (issue) begin
            r_pend_j <= r_j;
            r_j      <= r_j + CW'(1);
        end
        if (finish) begin
            r_out_idx   <= res_idx[INDEX_W-1:0];
            r_out_new   <= append;
            r_out_color <= r_code;
            r_out_ovf   <= r_ovf || ovf_set;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_pixel_index     = r_out_idx;
    assign o_new_entry       = r_out_new;
    assign o_entry_color     = r_out_color;
    assign o_too_many_colors = r_out_ovf;

    `PPI_ASSERT(a_used_range, (r_used >= CW'(1)) && (LW'(r_used) <= LW'(PALETTE_DEPTH)), "palette fill count out of range")
    `PPI_ASSERT(a_new_not_ovf, (r_out_valid && r_out_new) |-> !r_out_ovf, "new entry reported in an overflowed image")
    `PPI_ASSERT(a_ovf_idx_zero, (r_out_valid && r_out_ovf) |-> (r_out_idx == INDEX_W'(0)), "overflowed result with nonzero index")
    `PPI_ASSERT(a_append_count, append |=> (r_used == $past(r_used) + CW'(1)), "append did not advance the fill count")
    `PPI_ASSERT_ALWAYS(a_read_in_scan, issue |-> (r_state == ST_SCAN), "palette read outside a scan")

endmodule
